[rtl/mpsp_pkg.sv]
package mpsp_pkg;

  // Stream numbering limits (video E0+n, audio C0+n)
  localparam int VIDEO_STREAMS = 16;
  localparam int AUDIO_STREAMS = 32;

  // Start code suffixes
  localparam logic [7:0] SC_PACK     = 8'hBA;
  localparam logic [7:0] SC_SYSTEM   = 8'hBB;
  localparam logic [7:0] SC_PADDING  = 8'hBE;
  localparam logic [7:0] SC_PRIVATE2 = 8'hBF;
  localparam logic [7:0] SC_PROG_END = 8'hB9;

  localparam logic [7:0] STUFF_BYTE  = 8'hFF;
  localparam logic [7:0] NO_STAMP    = 8'h0F;

  // Result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_SCR     = 3'd1;
  localparam logic [2:0] KIND_PTS     = 3'd2;
  localparam logic [2:0] KIND_DTS     = 3'd3;
  localparam logic [2:0] KIND_STD     = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [32:0] time_stamp;
    logic        std_scale;
    logic [12:0] std_size;
    logic        is_audio;
    logic [4:0]  stream_index;
    logic        last_of_packet;
  } result_t;

  // 5 gathered bytes -> 33-bit clock value, marker bits dropped
  function automatic logic [32:0] decode_stamp(input logic [39:0] g);
    decode_stamp = {g[35:33], g[31:24], g[23:17], g[15:8], g[7:1]};
  endfunction

endpackage

[rtl/mpsp_parser.sv]
module mpsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        step_byte,
  output logic              res_vld,
  output mpsp_pkg::result_t res
);
  import mpsp_pkg::*;

  typedef enum logic [3:0] {
    PH_SYNC     = 4'd0,
    PH_PACK     = 4'd1,
    PH_LEN_SKIP = 4'd2,
    PH_LEN_AV   = 4'd3,
    PH_SKIP     = 4'd4,
    PH_STUFF    = 4'd5,
    PH_STD2     = 4'd6,
    PH_TSCHECK  = 4'd7,
    PH_PTS      = 4'd8,
    PH_DTSCHECK = 4'd9,
    PH_DTS      = 4'd10,
    PH_PAYLOAD  = 4'd11,
    PH_END      = 4'd12
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [23:0] win_r, win_nxt;      // last three bytes seen while searching
  logic [15:0] br_r, br_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [39:0] stamp_r, stamp_nxt;
  logic        aud_r, aud_nxt;
  logic [4:0]  stream_r, stream_nxt;
  logic        dts_r, dts_nxt;

  logic [15:0] br_dec;
  logic [3:0]  cnt_inc;
  logic [39:0] shifted;
  logic [15:0] len_full;
  logic        as_pay;
  logic        mk_hi, mk_pts;
  logic [7:0]  b;

  assign b       = step_byte;
  assign br_dec  = (br_r != 16'd0) ? br_r - 16'd1 : br_r;
  assign cnt_inc = cnt_r + 4'd1;
  assign shifted = {stamp_r[31:0], b};
  assign len_full = br_r | {8'h00, b};
  assign mk_hi   = (b[7:4] == 4'h3);
  assign mk_pts  = (b[7:4] == 4'h2) || mk_hi;

  always_comb begin
    phase_nxt  = phase_r;
    win_nxt    = win_r;
    br_nxt     = br_r;
    cnt_nxt    = cnt_r;
    stamp_nxt  = stamp_r;
    aud_nxt    = aud_r;
    stream_nxt = stream_r;
    dts_nxt    = dts_r;
    res_vld    = 1'b0;
    res        = '0;
    as_pay     = 1'b0;

    case (phase_r)
      PH_PACK: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc <= 4'd5) stamp_nxt = shifted;
        if (cnt_inc == 4'd5) begin
          res_vld         = 1'b1;
          res.kind        = KIND_SCR;
          res.time_stamp  = decode_stamp(shifted);
        end
        if (cnt_inc >= 4'd8) begin
          phase_nxt = PH_SYNC;
          win_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      PH_LEN_SKIP, PH_LEN_AV: begin
        if (cnt_r == 4'd0) begin
          br_nxt  = {b, 8'h00};
          cnt_nxt = 4'd1;
        end else begin
          br_nxt  = len_full;
          cnt_nxt = '0;
          if (len_full == 16'd0) begin
            phase_nxt = PH_SYNC;
            win_nxt   = '0;
          end else if (phase_r == PH_LEN_SKIP) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_STUFF;
          end
        end
      end
      PH_SKIP: begin
        br_nxt = br_dec;
        if (br_dec == 16'd0) begin
          phase_nxt = PH_SYNC;
          win_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      PH_END: begin
      end
      PH_STUFF, PH_STD2, PH_TSCHECK, PH_PTS, PH_DTSCHECK, PH_DTS, PH_PAYLOAD: begin
        br_nxt = br_dec;
        case (phase_r)
          PH_STUFF: begin
            if (b == STUFF_BYTE) begin
            end else if (b == NO_STAMP) begin
              phase_nxt = PH_PAYLOAD;
            end else if (b[7:6] == 2'b01) begin
              stamp_nxt = {32'h0, b};
              phase_nxt = PH_STD2;
            end else if (mk_pts) begin
              dts_nxt   = mk_hi;
              stamp_nxt = {32'h0, b};
              cnt_nxt   = 4'd1;
              phase_nxt = PH_PTS;
            end else begin
              phase_nxt = PH_PAYLOAD;
              as_pay    = 1'b1;
            end
          end
          PH_STD2: begin
            res_vld       = 1'b1;
            res.kind      = KIND_STD;
            res.std_scale = stamp_r[5];
            res.std_size  = {stamp_r[4:0], b};
            phase_nxt     = PH_TSCHECK;
          end
          PH_TSCHECK: begin
            if (b == NO_STAMP) begin
              phase_nxt = PH_PAYLOAD;
            end else if (mk_pts) begin
              dts_nxt   = mk_hi;
              stamp_nxt = {32'h0, b};
              cnt_nxt   = 4'd1;
              phase_nxt = PH_PTS;
            end else begin
              phase_nxt = PH_PAYLOAD;
              as_pay    = 1'b1;
            end
          end
          PH_PTS, PH_DTS: begin
            stamp_nxt = shifted;
            cnt_nxt   = cnt_inc;
            if (cnt_inc >= 4'd5) begin
              res_vld        = 1'b1;
              res.kind       = (phase_r == PH_PTS) ? KIND_PTS : KIND_DTS;
              res.time_stamp = decode_stamp(shifted);
              cnt_nxt        = '0;
              phase_nxt      = (phase_r == PH_PTS && dts_r) ? PH_DTSCHECK : PH_PAYLOAD;
            end
          end
          PH_DTSCHECK: begin
            if (b[7:4] == 4'h1) begin
              stamp_nxt = {32'h0, b};
              cnt_nxt   = 4'd1;
              phase_nxt = PH_DTS;
            end else begin
              phase_nxt = PH_PAYLOAD;
              as_pay    = 1'b1;
            end
          end
          default: as_pay = 1'b1;
        endcase
        if (as_pay) begin
          res_vld            = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.payload_byte   = b;
          res.last_of_packet = (br_dec == 16'd0);
        end
        if (res_vld) begin
          res.is_audio     = aud_r;
          res.stream_index = stream_r;
        end
        // length runs out: packet ends, even mid-header
        if (br_dec == 16'd0) begin
          phase_nxt = PH_SYNC;
          win_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      default: begin
        // search: slide window, look for 00 00 01 xx
        win_nxt = {win_r[15:0], b};
        if (win_r == 24'h000001) begin
          cnt_nxt = '0;
          win_nxt = '0;
          if (b == SC_PACK) begin
            stamp_nxt = '0;
            phase_nxt = PH_PACK;
          end else if (b == SC_SYSTEM || b == SC_PADDING || b == SC_PRIVATE2) begin
            phase_nxt = PH_LEN_SKIP;
          end else if (b == SC_PROG_END) begin
            phase_nxt = PH_END;
          end else if (b[7:4] == 4'hE && {1'b0, b[3:0]} < 5'(VIDEO_STREAMS)) begin
            aud_nxt    = 1'b0;
            stream_nxt = b[4:0];
            phase_nxt  = PH_LEN_AV;
          end else if (b[7:5] == 3'b110 && {1'b0, b[4:0]} < 6'(AUDIO_STREAMS)) begin
            aud_nxt    = 1'b1;
            stream_nxt = b[4:0];
            phase_nxt  = PH_LEN_AV;
          end else begin
            win_nxt = {win_r[15:0], b};  // unknown code, keep sliding
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC;
      win_r    <= '0;
      br_r     <= '0;
      cnt_r    <= '0;
      stamp_r  <= '0;
      aud_r    <= 1'b0;
      stream_r <= '0;
      dts_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      win_r    <= win_nxt;
      br_r     <= br_nxt;
      cnt_r    <= cnt_nxt;
      stamp_r  <= stamp_nxt;
      aud_r    <= aud_nxt;
      stream_r <= stream_nxt;
      dts_r    <= dts_nxt;
    end
  end

endmodule

[rtl/mpeg1_program_stream_parser_top.sv]
// MPEG-1 program stream parser. Bytes enter on the in_ channel one per
// transaction and are parsed at a sustained rate of one byte per clock
// while out_stall does not hold the output register full. A byte is
// captured in an input register, parsed by one step of shallow logic,
// and any result lands in the output register, from which it shows on
// the out_ channel. The output register parts the two sides, so a new
// byte is taken while a result waits; in_stall rises only while both
// the input and output registers are full and the output is stalled.
// Results: SCR per pack header, STD buffer info, PTS and DTS of
// audio/video packets, then payload bytes tagged with the stream and
// with the last byte of each packet marked. System, padding and
// private-2 packets are skipped; after a program end code every byte
// is dropped until reset.
module mpeg1_program_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [32:0] out_time_stamp,
  output logic        out_std_scale,
  output logic [12:0] out_std_size,
  output logic        out_is_audio,
  output logic [4:0]  out_stream_index,
  output logic        out_last_of_packet
);
  import mpsp_pkg::*;

  // input register
  logic       byte_vld_r;
  logic [7:0] byte_r;

  // output register
  logic       out_vld_r;
  result_t    out_r;

  // parser step result
  logic       step_vld;
  result_t    step_res;
  logic       advance;

  // a byte is parsed when the output register is free or being emptied
  assign advance  = byte_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = byte_vld_r && !advance;

  mpsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_byte (byte_r),
    .res_vld   (step_vld),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        byte_vld_r <= 1'b1;
      end else if (advance) begin
        byte_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= step_vld;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_stream_byte;
    end
    if (advance && step_vld) begin
      out_r <= step_res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_result_kind    = out_r.kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_time_stamp     = out_r.time_stamp;
  assign out_std_scale      = out_r.std_scale;
  assign out_std_size       = out_r.std_size;
  assign out_is_audio       = out_r.is_audio;
  assign out_stream_index   = out_r.stream_index;
  assign out_last_of_packet = out_r.last_of_packet;

`ifndef ASSERT_OFF
  // only payload bytes may close a packet
  a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_PAYLOAD |-> !out_last_of_packet)
    else $error("last_of_packet set on a non-payload result");

  // SCR carries no stream tag
  a_scr_no_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_SCR |-> !out_is_audio && out_stream_index == 5'd0)
    else $error("SCR result tagged with a stream");

  // a held byte is not lost while the output is blocked
  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !advance |=> byte_vld_r && $stable(byte_r))
    else $error("input byte dropped while stalled");

  // kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= KIND_STD)
    else $error("undefined result kind");
`endif

endmodule

[dv/tb_mpeg1_program_stream_parser_top.sv]
module tb_mpeg1_program_stream_parser_top;
  import mpsp_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RANDOM_BYTES  = 1030;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_AFTER    = 300;   // bytes taken before the long output hold
  localparam int HOLD_CYCLES   = 200;

  // Stream id bases and the marker bits that open header fields
  localparam logic [7:0] VIDEO_BASE   = 8'hE0;
  localparam logic [7:0] AUDIO_BASE   = 8'hC0;
  localparam logic [1:0] STD_TAG      = 2'b01;
  localparam logic [3:0] PTS_ONLY_TAG = 4'h2;
  localparam logic [3:0] PTS_DTS_TAG  = 4'h3;
  localparam logic [3:0] DTS_TAG      = 4'h1;

  typedef enum logic [3:0] {
    P_HUNT, P_PACK, P_SKIP_LEN, P_AV_LEN, P_SKIP, P_STUFF, P_STD_LO,
    P_STAMP_LEAD, P_PTS, P_DTS_LEAD, P_DTS, P_PAYLOAD, P_HALT
  } phase_t;

  typedef enum logic [1:0] {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

  // One byte of stimulus; 'typed' rows carry their expected result directly
  typedef struct {
    logic [7:0] data;
    bit         typed;
    result_t    want;
  } feed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [32:0] out_time_stamp;
  logic        out_std_scale;
  logic [12:0] out_std_size;
  logic        out_is_audio;
  logic [4:0]  out_stream_index;
  logic        out_last_of_packet;

  mpeg1_program_stream_parser_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_time_stamp    (out_time_stamp),
    .out_std_scale     (out_std_scale),
    .out_std_size      (out_std_size),
    .out_is_audio      (out_is_audio),
    .out_stream_index  (out_stream_index),
    .out_last_of_packet(out_last_of_packet)
  );

  // ---------------------------------------------------------------------------
  // Demux model state: mirrors the parser's registers, reset values as declared
  // ---------------------------------------------------------------------------
  logic [31:0] hunt_window = '0;     // last four bytes while looking for a start code
  phase_t      phase       = P_HUNT;
  logic [15:0] left_n      = '0;     // bytes left in the current packet
  logic [3:0]  field_n     = '0;     // byte count within a length/stamp/SCR field
  logic [39:0] gather      = '0;     // time stamp bytes or first STD byte
  logic        pkt_audio   = 1'b0;
  logic [4:0]  pkt_stream  = '0;
  logic        dts_pending = 1'b0;   // PTS lead said a DTS should follow

  feed_row_t   byte_feed[$];         // whole stimulus, in order
  feed_row_t   cur_row;              // row currently offered on the in_ channel
  result_t     pending_results[$];   // expected results, oldest first
  int          bytes_taken = 0;
  int          cycles = 0;
  bit          failed = 1'b0;

  // 5 gathered bytes -> 33-bit clock value
  function automatic logic [32:0] stamp_value(input logic [39:0] g);
    return ((33'(g[39:32] & 8'h0E) >> 1) << 30)
         | (33'(g[31:24]) << 22)
         | ((33'(g[23:16] & 8'hFE) >> 1) << 15)
         | (33'(g[15:8]) << 7)
         | (33'(g[7:0] & 8'hFE) >> 1);
  endfunction

  task automatic to_hunt();
    phase       = P_HUNT;
    hunt_window = '0;
    field_n     = '0;
  endtask

  // First byte after stuffing/STD: no-stamp marker, PTS lead, or payload
  task automatic stamp_lead(input logic [7:0] b, output bit as_pay);
    as_pay = 1'b0;
    if (b == NO_STAMP) begin
      phase = P_PAYLOAD;
    end else if (b[7:4] == PTS_ONLY_TAG || b[7:4] == PTS_DTS_TAG) begin
      dts_pending = (b[7:4] == PTS_DTS_TAG);
      gather      = {32'd0, b};
      field_n     = 4'd1;
      phase       = P_PTS;
    end else begin
      phase  = P_PAYLOAD;
      as_pay = 1'b1;
    end
  endtask

  // Advance the model by one stream byte; got=1 when a result is due
  task automatic demux_byte(input logic [7:0] b, output bit got, output result_t r);
    logic [7:0] c;
    bit as_pay;
    bit stream_tag;
    got        = 1'b0;
    r          = '0;
    as_pay     = 1'b0;
    stream_tag = 1'b1;
    case (phase)
      P_HUNT: begin
        hunt_window = {hunt_window[23:0], b};
        if (hunt_window[31:8] == 24'h000001) begin
          c       = hunt_window[7:0];
          field_n = '0;
          if (c == SC_PACK) begin
            gather = '0;
            phase  = P_PACK;
          end else if (c == SC_SYSTEM || c == SC_PADDING || c == SC_PRIVATE2) begin
            phase = P_SKIP_LEN;
          end else if (c == SC_PROG_END) begin
            phase = P_HALT;
          end else if (c >= VIDEO_BASE && c < VIDEO_BASE + VIDEO_STREAMS) begin
            pkt_audio  = 1'b0;
            pkt_stream = 5'(c - VIDEO_BASE);
            phase      = P_AV_LEN;
          end else if (c >= AUDIO_BASE && c < AUDIO_BASE + AUDIO_STREAMS) begin
            pkt_audio  = 1'b1;
            pkt_stream = 5'(c - AUDIO_BASE);
            phase      = P_AV_LEN;
          end
          // unknown codes leave the window sliding
          if (phase != P_HUNT) hunt_window = '0;
        end
      end
      P_PACK: begin
        field_n = field_n + 4'd1;
        if (field_n <= 4'd5) gather = {gather[31:0], b};
        if (field_n == 4'd5) begin
          got          = 1'b1;
          r.kind       = KIND_SCR;
          r.time_stamp = stamp_value(gather);
          stream_tag   = 1'b0;
        end
        if (field_n >= 4'd8) to_hunt();
      end
      P_SKIP_LEN, P_AV_LEN: begin
        if (field_n == '0) begin
          left_n  = {b, 8'h00};
          field_n = 4'd1;
        end else begin
          left_n  = left_n | {8'h00, b};
          field_n = '0;
          if (left_n == '0) to_hunt();
          else phase = (phase == P_SKIP_LEN) ? P_SKIP : P_STUFF;
        end
      end
      P_SKIP: begin
        if (left_n != '0) left_n = left_n - 16'd1;
        if (left_n == '0) to_hunt();
      end
      P_HALT: begin
      end
      default: begin
        // every byte of an A/V packet counts against its length, header too
        if (left_n != '0) left_n = left_n - 16'd1;
        case (phase)
          P_STUFF: begin
            if (b != STUFF_BYTE) begin
              if (b == NO_STAMP) begin
                phase = P_PAYLOAD;
              end else if (b[7:6] == STD_TAG) begin
                gather = {32'd0, b};
                phase  = P_STD_LO;
              end else begin
                stamp_lead(b, as_pay);
              end
            end
          end
          P_STD_LO: begin
            got         = 1'b1;
            r.kind      = KIND_STD;
            r.std_scale = gather[5];
            r.std_size  = {gather[4:0], b};
            phase       = P_STAMP_LEAD;
          end
          P_STAMP_LEAD: stamp_lead(b, as_pay);
          P_PTS, P_DTS: begin
            gather  = {gather[31:0], b};
            field_n = field_n + 4'd1;
            if (field_n >= 4'd5) begin
              got          = 1'b1;
              r.kind       = (phase == P_PTS) ? KIND_PTS : KIND_DTS;
              r.time_stamp = stamp_value(gather);
              field_n      = '0;
              phase        = (phase == P_PTS && dts_pending) ? P_DTS_LEAD : P_PAYLOAD;
            end
          end
          P_DTS_LEAD: begin
            if (b[7:4] == DTS_TAG) begin
              gather  = {32'd0, b};
              field_n = 4'd1;
              phase   = P_DTS;
            end else begin
              phase  = P_PAYLOAD;
              as_pay = 1'b1;
            end
          end
          default: as_pay = 1'b1;
        endcase
        if (as_pay) begin
          got            = 1'b1;
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
        end
        if (left_n == '0) to_hunt();
      end
    endcase
    if (got) begin
      if (stream_tag) begin
        r.is_audio     = pkt_audio;
        r.stream_index = pkt_stream;
      end
      r.last_of_packet = (r.kind == KIND_PAYLOAD) && (left_n == '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic result_t res(input logic [2:0] kind, input logic [7:0] pay,
                                  input logic [32:0] ts, input logic sc,
                                  input logic [12:0] sz, input logic aud,
                                  input logic [4:0] idx, input logic last);
    result_t r;
    r.kind           = kind;
    r.payload_byte   = pay;
    r.time_stamp     = ts;
    r.std_scale      = sc;
    r.std_size       = sz;
    r.is_audio       = aud;
    r.stream_index   = idx;
    r.last_of_packet = last;
    return r;
  endfunction

  task automatic row(input logic [7:0] b, input bit typed = 1'b0, input result_t want = '0);
    feed_row_t f;
    f.data  = b;
    f.typed = typed;
    f.want  = want;
    byte_feed.push_back(f);
  endtask

  task automatic start_code(input logic [7:0] c);
    row(8'h00); row(8'h00); row(8'h01); row(c);
  endtask

  task automatic rand_bytes(input int n);
    repeat (n) row(8'($urandom));
  endtask

  // One random unit of program stream; mostly well-formed, some noise/breakage
  task automatic add_unit(input bit pack_only);
    int          pick;
    logic [15:0] len;
    logic [7:0]  c;
    logic [7:0]  body[$];
    pick = pack_only ? 20 : $urandom_range(0, 99);
    if (pick < 8) begin
      // line noise while hunting
      rand_bytes($urandom_range(1, 8));
    end else if (pick < 12) begin
      // start code that the parser does not know (never program end)
      do begin
        c = 8'($urandom);
      end while (c == SC_PACK || c == SC_SYSTEM || c == SC_PADDING ||
                 c == SC_PRIVATE2 || c == SC_PROG_END ||
                 (c >= VIDEO_BASE && c < VIDEO_BASE + VIDEO_STREAMS) ||
                 (c >= AUDIO_BASE && c < AUDIO_BASE + AUDIO_STREAMS));
      start_code(c);
    end else if (pick < 25) begin
      start_code(SC_PACK);
      rand_bytes(8);
    end else if (pick < 37) begin
      case ($urandom_range(0, 2))
        0:       c = SC_SYSTEM;
        1:       c = SC_PADDING;
        default: c = SC_PRIVATE2;
      endcase
      len = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
      start_code(c);
      row(len[15:8]);
      row(len[7:0]);
      rand_bytes(int'(len));
    end else begin
      if ($urandom_range(0, 1)) c = 8'(VIDEO_BASE + $urandom_range(0, VIDEO_STREAMS - 1));
      else c = 8'(AUDIO_BASE + $urandom_range(0, AUDIO_STREAMS - 1));
      repeat ($urandom_range(0, 3)) body.push_back(STUFF_BYTE);
      if ($urandom_range(0, 1)) begin
        body.push_back({STD_TAG, 6'($urandom)});
        body.push_back(8'($urandom));
      end
      case ($urandom_range(0, 4))
        0: body.push_back(NO_STAMP);
        1: begin
          body.push_back({PTS_ONLY_TAG, 4'($urandom)});
          repeat (4) body.push_back(8'($urandom));
        end
        2: begin
          body.push_back({PTS_DTS_TAG, 4'($urandom)});
          repeat (4) body.push_back(8'($urandom));
          // now and then a bad DTS lead, which turns into payload
          body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                     : {DTS_TAG, 4'($urandom)});
          repeat (4) body.push_back(8'($urandom));
        end
        default: begin
          // no marker: the first payload byte decides what happens
        end
      endcase
      repeat ($urandom_range(0, 24)) body.push_back(8'($urandom));
      len = 16'(body.size());
      // broken length: cuts the header short or runs into the next unit
      if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, body.size() + 6));
      start_code(c);
      row(len[15:8]);
      row(len[7:0]);
      foreach (body[i]) row(body[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predict on every accepted byte, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t w;
    result_t model_r;
    bit      model_got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result_kind: expected none, actual %0d", out_result_kind);
          failed = 1'b1;
        end else begin
          w = pending_results.pop_front();
          if (out_result_kind !== w.kind) begin
            $error("result_kind: expected %0d, actual %0d", w.kind, out_result_kind);
            failed = 1'b1;
          end
          if (out_payload_byte !== w.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", w.payload_byte,
                   out_payload_byte);
            failed = 1'b1;
          end
          if (out_time_stamp !== w.time_stamp) begin
            $error("time_stamp: expected %0h, actual %0h", w.time_stamp, out_time_stamp);
            failed = 1'b1;
          end
          if (out_std_scale !== w.std_scale) begin
            $error("std_scale: expected %0d, actual %0d", w.std_scale,
                   out_std_scale);
            failed = 1'b1;
          end
          if (out_std_size !== w.std_size) begin
            $error("std_size: expected %0h, actual %0h", w.std_size, out_std_size);
            failed = 1'b1;
          end
          if (out_is_audio !== w.is_audio) begin
            $error("is_audio: expected %0d, actual %0d", w.is_audio, out_is_audio);
            failed = 1'b1;
          end
          if (out_stream_index !== w.stream_index) begin
            $error("stream_index: expected %0d, actual %0d", w.stream_index,
                   out_stream_index);
            failed = 1'b1;
          end
          if (out_last_of_packet !== w.last_of_packet) begin
            $error("last_of_packet: expected %0d, actual %0d", w.last_of_packet,
                   out_last_of_packet);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        // model always advances; a typed row overrides what it predicts
        demux_byte(in_stream_byte, model_got, model_r);
        if (cur_row.typed) pending_results.push_back(cur_row.want);
        else if (model_got) pending_results.push_back(model_r);
        bytes_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern plus one long hold so the parser backs up
  // ---------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int          mode_left;
    bit          held;
    mode      = FLOW;
    mode_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && bytes_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          FLOW:    out_stall <= 1'b0;
          LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cycles[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, random units, then program end, which is final
  // ---------------------------------------------------------------------------
  initial begin
    int burst_left;
    int gap;
    int directed_n;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_byte = 8'h00;
    cur_row.data   = 8'h00;
    cur_row.typed  = 1'b0;
    cur_row.want   = '0;

    // pack header with the largest SCR, then 3 mux-rate bytes
    start_code(SC_PACK);
    row(8'h2F); row(8'hFF); row(8'hFF); row(8'hFF);
    row(8'hFF, 1'b1, res(KIND_SCR, 8'h00, 33'h1_FFFF_FFFF, 1'b0, 13'h0, 1'b0, 5'd0, 1'b0));
    row(8'h00); row(8'h00); row(8'h00);
    // unknown code: hunting keeps sliding straight into the next code
    start_code(8'hB0);
    // top audio stream: stuffing, largest STD field, PTS of zero, two payload bytes
    start_code(8'(AUDIO_BASE + AUDIO_STREAMS - 1));
    row(8'h00); row(8'h0A);
    row(STUFF_BYTE);
    row(8'h7F);
    row(8'hFF, 1'b1, res(KIND_STD, 8'h00, 33'h0, 1'b1, 13'h1FFF, 1'b1, 5'd31, 1'b0));
    row(8'h21); row(8'h00); row(8'h01); row(8'h00);
    row(8'h01, 1'b1, res(KIND_PTS, 8'h00, 33'h0, 1'b0, 13'h0, 1'b1, 5'd31, 1'b0));
    row(8'h00, 1'b1, res(KIND_PAYLOAD, 8'h00, 33'h0, 1'b0, 13'h0, 1'b1, 5'd31, 1'b0));
    row(8'hFF, 1'b1, res(KIND_PAYLOAD, 8'hFF, 33'h0, 1'b0, 13'h0, 1'b1, 5'd31, 1'b1));
    // top video stream with zero length: ends at once
    start_code(8'(VIDEO_BASE + VIDEO_STREAMS - 1));
    row(8'h00); row(8'h00);
    // video 0: largest PTS and DTS, one payload byte
    start_code(VIDEO_BASE);
    row(8'h00); row(8'h0B);
    row(8'h3F); row(8'hFF); row(8'hFF); row(8'hFF);
    row(8'hFF, 1'b1, res(KIND_PTS, 8'h00, 33'h1_FFFF_FFFF, 1'b0, 13'h0, 1'b0, 5'd0, 1'b0));
    row(8'h1F); row(8'hFF); row(8'hFF); row(8'hFF);
    row(8'hFF, 1'b1, res(KIND_DTS, 8'h00, 33'h1_FFFF_FFFF, 1'b0, 13'h0, 1'b0, 5'd0, 1'b0));
    row(8'h55, 1'b1, res(KIND_PAYLOAD, 8'h55, 33'h0, 1'b0, 13'h0, 1'b0, 5'd0, 1'b1));
    // bad header byte where a marker belongs: it becomes payload
    start_code(AUDIO_BASE);
    row(8'h00); row(8'h01);
    row(8'h80, 1'b1, res(KIND_PAYLOAD, 8'h80, 33'h0, 1'b0, 13'h0, 1'b1, 5'd0, 1'b1));
    // no-stamp marker, then payload
    start_code(8'(AUDIO_BASE + 5));
    row(8'h00); row(8'h02); row(NO_STAMP); row(8'h44);
    // length runs out in the middle of a PTS
    start_code(8'(VIDEO_BASE + 7));
    row(8'h00); row(8'h03); row(8'h31); row(8'hFF); row(8'hFF);
    // system header skipped by length
    start_code(SC_SYSTEM);
    row(8'h00); row(8'h02); row(8'h00); row(8'h00);
    directed_n = byte_feed.size();

    while (byte_feed.size() < directed_n + RANDOM_BYTES) add_unit(1'b0);
    // leave the parser hunting before program end
    add_unit(1'b1);

    // program end: the bytes after it are dropped, so it goes last
    start_code(SC_PROG_END);
    start_code(SC_PACK);
    row(8'h21); row(8'h00); row(8'h01); row(8'h00); row(8'h01);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender: bursts of random length, random gaps between them
    burst_left = 0;
    foreach (byte_feed[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      @(negedge clk);
      cur_row = byte_feed[i];
      in_valid       <= 1'b1;
      in_stream_byte <= byte_feed[i].data;
      do @(posedge clk); while (in_stall);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
